// ===== hw/rtl/rld_pkg.sv =====
package rld_pkg;

  // Width of the saturating decoded-size counter (16 to 64)
  localparam int unsigned TotalWidth = 32;

  // Fixed widths of the stream fields
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 14;
  localparam int unsigned LitWidth   = 7;
  localparam int unsigned TotOutW    = 32;

  // Header decode constants
  localparam logic [ByteWidth-1:0]  RunHdrMin  = 8'h80;
  localparam logic [ByteWidth-1:0]  LongHdrMin = 8'hE0;
  localparam logic [CountWidth-1:0] ShortBias  = 14'd2;
  localparam logic [CountWidth-1:0] LongBias   = 14'd98;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhLiteral = 2'd1,
    PhLength  = 2'd2,
    PhFill    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [ByteWidth-1:0]  value;
    logic [CountWidth-1:0] count;
    logic [TotalWidth-1:0] total;
    logic                  truncated;
    logic                  finished;
  } rld_result_t;

endpackage

// ===== hw/rtl/rld_parser.sv =====
module rld_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           code_byte_i,
  input  logic                 block_end_i,
  output logic                 res_valid_o,
  output rld_pkg::rld_result_t res_o
);
  import rld_pkg::*;

  phase_e                phase_q, phase_d;
  logic [LitWidth-1:0]   lit_left_q, lit_left_d;
  logic [CountWidth-1:0] run_len_q, run_len_d;
  logic [TotalWidth-1:0] total_q, total_d;

  logic [CountWidth-1:0] add_amt;
  logic [TotalWidth:0]   add_sum;
  logic [TotalWidth-1:0] total_sat;

  // Saturating add of the current amount to the running total
  always_comb begin
    add_amt = (phase_q == PhFill) ? run_len_q : CountWidth'(1);
    add_sum = {1'b0, total_q} + (TotalWidth + 1)'(add_amt);
    total_sat = add_sum[TotalWidth] ? {TotalWidth{1'b1}} : add_sum[TotalWidth-1:0];
  end

  // Phase update and result forming
  always_comb begin
    phase_d     = phase_q;
    lit_left_d  = lit_left_q;
    run_len_d   = run_len_q;
    total_d     = total_q;
    res_valid_o = 1'b0;
    res_o       = '{value: '0, count: '0, total: total_q,
                    truncated: 1'b1, finished: 1'b1};
    case (phase_q)
      PhHeader: begin
        if (code_byte_i < RunHdrMin) begin
          lit_left_d = code_byte_i[LitWidth-1:0];
          phase_d    = PhLiteral;
        end else if (code_byte_i < LongHdrMin) begin
          run_len_d = CountWidth'(code_byte_i[6:0]) + ShortBias;
          phase_d   = PhFill;
        end else begin
          run_len_d = {1'b0, code_byte_i[4:0], 8'h00};
          phase_d   = PhLength;
        end
        res_valid_o = block_end_i;
      end
      PhLiteral: begin
        total_d = total_sat;
        if (lit_left_q != '0) begin
          lit_left_d = lit_left_q - LitWidth'(1);
        end else begin
          phase_d = PhHeader;
        end
        res_valid_o = 1'b1;
        res_o = '{value: code_byte_i, count: CountWidth'(1), total: total_sat,
                  truncated: block_end_i && (lit_left_q != '0),
                  finished: block_end_i};
      end
      PhLength: begin
        run_len_d   = run_len_q + CountWidth'(code_byte_i) + LongBias;
        phase_d     = PhFill;
        res_valid_o = block_end_i;
      end
      default: begin
        total_d     = total_sat;
        phase_d     = PhHeader;
        run_len_d   = '0;
        res_valid_o = 1'b1;
        res_o = '{value: code_byte_i, count: run_len_q, total: total_sat,
                  truncated: 1'b0, finished: block_end_i};
      end
    endcase
    // Restart the parser after the final byte of a block
    if (block_end_i) begin
      phase_d    = PhHeader;
      lit_left_d = '0;
      run_len_d  = '0;
      total_d    = '0;
    end
  end

  // Advance parse state on each consumed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      lit_left_q <= '0;
      run_len_q  <= '0;
      total_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      run_len_q  <= run_len_d;
      total_q    <= total_d;
    end
  end

endmodule

// ===== hw/rtl/run_length_decoder.sv =====
// Run-length decoder. Takes one encoded byte per beat on the slave side
// (tlast marks the final byte of a block) and gives one (value, count,
// decoded_total) beat per literal byte or fill byte on the master side;
// header and length bytes give no beat unless they end the block, in which
// case a beat with count 0 and tuser (truncated) high closes it. tlast on
// the master side marks the beat that closes a block, after which the
// running total restarts at zero. The block takes one byte every cycle
// while the sink keeps up: a byte is held in the input register, is parsed
// by the phase logic and lands in the result register. tready drops only
// while the result register holds a beat that the sink does not take.
module run_length_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  logic        s_axis_tlast,   // block_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] value, [21:8] count,
                                      // [53:22] decoded_total, [55:54] zero
  output logic        m_axis_tuser,   // truncated
  output logic        m_axis_tlast    // finished
);
  import rld_pkg::*;

  logic              in_v_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_v_q;
  rld_result_t       out_q;
  logic              step;
  logic              res_valid;
  rld_result_t       res;
  logic [TotOutW-1:0] total_out;

  // Consume the held byte whenever the result register can take its beat
  assign step          = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  rld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .code_byte_i (in_byte_q),
    .block_end_i (in_last_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step) begin
      out_v_q <= res_valid;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  // Show the low bits of the running total, zero-extended if it is narrower
  if (TotalWidth >= TotOutW) begin : g_tot_trunc
    assign total_out = out_q.total[TotOutW-1:0];
  end else begin : g_tot_ext
    assign total_out = {{(TotOutW - TotalWidth){1'b0}}, out_q.total};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, total_out, out_q.count, out_q.value};
  assign m_axis_tuser  = out_q.truncated;
  assign m_axis_tlast  = out_q.finished;

  // A zero count only ever appears on a truncated block end
  a_zero_count_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[21:8] == 14'd0)) |-> m_axis_tuser)
    else $error("zero count without truncation");

  // A truncated beat always closes its block
  a_trunc_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("truncated beat does not close the block");

  // Run length never exceeds the longest code
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:8] <= 14'd8289))
    else $error("count out of range");

  // A held byte with a free result register is consumed at once
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_v_q) |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

// ===== dv/run_length_decoder_tb.sv =====
`timescale 1ns / 1ps

module run_length_decoder_tb;
  import rld_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 1400;
  localparam int unsigned HoldAfter     = 300;
  localparam int unsigned HoldCycles    = 250;

  // One encoded byte as offered on the slave side
  typedef struct packed {
    logic [ByteWidth-1:0] code;
    logic                 last;
  } code_beat_t;

  // One decoded (value, count) beat as seen on the master side
  typedef struct packed {
    logic [ByteWidth-1:0]  value;
    logic [CountWidth-1:0] count;
    logic [TotOutW-1:0]    total;
    logic                  truncated;
    logic                  finished;
  } run_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  run_length_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  code_beat_t  pending_bytes[$];
  code_beat_t  block_bytes[$];
  run_beat_t   expected_runs[$];
  int unsigned bytes_to_send;
  int unsigned bytes_accepted = 0;
  int unsigned mismatches = 0;

  // Parser state mirrored by the decode model
  phase_e                dec_phase = PhHeader;
  logic [LitWidth-1:0]   dec_lits_left = '0;
  logic [CountWidth-1:0] dec_run_len = '0;
  logic [TotalWidth-1:0] dec_total = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Gap length: mostly short, a few long, with occasional bursts of no gaps
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst != 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst = $urandom_range(80, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [TotalWidth-1:0] add_saturating(logic [TotalWidth-1:0] acc,
                                                           logic [CountWidth-1:0] amount);
    logic [TotalWidth:0] sum;
    sum = {1'b0, acc} + (TotalWidth + 1)'(amount);
    return sum[TotalWidth] ? '1 : sum[TotalWidth-1:0];
  endfunction

  // Advance the parser by one byte and queue the beat it produces, if any
  task automatic decode_byte(input code_beat_t beat);
    run_beat_t res;
    bit        emit;
    bit        more;
    res  = '0;
    emit = 1'b0;
    case (dec_phase)
      PhHeader: begin
        if (beat.code < RunHdrMin) begin
          dec_lits_left = beat.code[LitWidth-1:0];
          dec_phase     = PhLiteral;
        end else if (beat.code < LongHdrMin) begin
          dec_run_len = CountWidth'(beat.code[6:0]) + ShortBias;
          dec_phase   = PhFill;
        end else begin
          dec_run_len = CountWidth'({beat.code[4:0], 8'h00});
          dec_phase   = PhLength;
        end
        // block ends before any data of the code
        if (beat.last) begin
          emit          = 1'b1;
          res.truncated = 1'b1;
          res.finished  = 1'b1;
          res.total     = dec_total[TotOutW-1:0];
        end
      end
      PhLiteral: begin
        more      = dec_lits_left != 0;
        dec_total = add_saturating(dec_total, CountWidth'(1));
        if (more) dec_lits_left = dec_lits_left - LitWidth'(1);
        else dec_phase = PhHeader;
        emit          = 1'b1;
        res.value     = beat.code;
        res.count     = CountWidth'(1);
        res.total     = dec_total[TotOutW-1:0];
        res.truncated = beat.last && more;
        res.finished  = beat.last;
      end
      PhLength: begin
        dec_run_len = dec_run_len + CountWidth'(beat.code) + LongBias;
        dec_phase   = PhFill;
        if (beat.last) begin
          emit          = 1'b1;
          res.truncated = 1'b1;
          res.finished  = 1'b1;
          res.total     = dec_total[TotOutW-1:0];
        end
      end
      default: begin
        dec_total     = add_saturating(dec_total, dec_run_len);
        emit          = 1'b1;
        res.value     = beat.code;
        res.count     = dec_run_len;
        res.total     = dec_total[TotOutW-1:0];
        res.finished  = beat.last;
        dec_phase     = PhHeader;
        dec_run_len   = '0;
      end
    endcase
    if (emit) expected_runs.push_back(res);
    // the block's last byte restarts the parser
    if (beat.last) begin
      dec_phase     = PhHeader;
      dec_lits_left = '0;
      dec_run_len   = '0;
      dec_total     = '0;
    end
  endtask

  task automatic add_beat(input logic [7:0] code, input logic last);
    code_beat_t b;
    b.code = code;
    b.last = last;
    block_bytes.push_back(b);
  endtask

  task automatic flush_block();
    while (block_bytes.size() != 0) pending_bytes.push_back(block_bytes.pop_front());
  endtask

  // Build one block of well-formed codes; optionally cut it inside the last code
  task automatic add_block(input int unsigned n_codes, input bit cut);
    int unsigned code_start;
    int unsigned n_lits;
    int unsigned keep;
    code_start = 0;
    for (int unsigned i = 0; i < n_codes; i++) begin
      code_start = block_bytes.size();
      case ($urandom_range(2))
        0: begin
          case ($urandom_range(19))
            0:       n_lits = 128;
            1:       n_lits = $urandom_range(128, 1);
            default: n_lits = $urandom_range(6, 1);
          endcase
          add_beat(8'(n_lits - 1), 1'b0);
          for (int unsigned k = 0; k < n_lits; k++) add_beat(8'($urandom), 1'b0);
        end
        1: begin
          add_beat(8'($urandom_range(8'hDF, 8'h80)), 1'b0);
          add_beat(8'($urandom), 1'b0);
        end
        default: begin
          add_beat(8'($urandom_range(8'hFF, 8'hE0)), 1'b0);
          add_beat(8'($urandom), 1'b0);
          add_beat(8'($urandom), 1'b0);
        end
      endcase
    end
    if (cut) begin
      keep = $urandom_range(block_bytes.size() - 1, code_start + 1);
      while (block_bytes.size() > keep) void'(block_bytes.pop_back());
    end
    block_bytes[block_bytes.size() - 1].last = 1'b1;
    flush_block();
  endtask

  task automatic add_noise();
    int unsigned n;
    n = $urandom_range(12, 1);
    for (int unsigned i = 0; i < n; i++) add_beat(8'($urandom), ($urandom_range(5) == 0));
    block_bytes[block_bytes.size() - 1].last = 1'b1;
    flush_block();
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: feed pending bytes, with random gaps between beats
  int unsigned in_gap = 0;
  int unsigned in_burst = 0;
  code_beat_t  in_beat = '0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(in_beat);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap != 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_beat = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= in_beat.code;
          s_axis_tlast  <= in_beat.last;
          in_gap = pick_gap(in_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each decoded beat, stall at random, and hold off once for long
  int unsigned out_stall = 0;
  int unsigned out_burst = 0;
  int unsigned out_hold = 0;
  int unsigned runs_seen = 0;
  bit          hold_done = 1'b0;
  run_beat_t   want_run;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        runs_seen++;
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected beat value %0d count %0d total %0d", $time,
                   m_axis_tdata[7:0], m_axis_tdata[21:8], m_axis_tdata[53:22]);
          mismatches++;
        end else begin
          want_run = expected_runs.pop_front();
          check_field("value", 32'(want_run.value), 32'(m_axis_tdata[7:0]));
          check_field("count", 32'(want_run.count), 32'(m_axis_tdata[21:8]));
          check_field("decoded_total", 32'(want_run.total), 32'(m_axis_tdata[53:22]));
          check_field("truncated", 32'(want_run.truncated), 32'(m_axis_tuser));
          check_field("finished", 32'(want_run.finished), 32'(m_axis_tlast));
        end
      end
      if (out_hold != 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && runs_seen >= HoldAfter) begin
        hold_done = 1'b1;
        out_hold  = HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (out_stall != 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_stall = pick_gap(out_burst);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // empty-ish literal group, then runs at their length extremes
    add_beat(8'h00, 1'b1);
    add_beat(8'h00, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(RunHdrMin, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hDF, 1'b0);
    add_beat(8'h5A, 1'b0);
    add_beat(LongHdrMin, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(8'h11, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hA5, 1'b1);
    // block ends inside a literal group
    add_beat(8'h01, 1'b0);
    add_beat(8'h33, 1'b1);
    // block ends on a header, then on a long-run length byte
    add_beat(8'hC0, 1'b1);
    add_beat(8'hE5, 1'b0);
    add_beat(8'h10, 1'b1);
    // block ends on a fill byte, then on the final literal of a group
    add_beat(8'h81, 1'b0);
    add_beat(8'h00, 1'b1);
    add_beat(8'h00, 1'b0);
    add_beat(8'h7E, 1'b1);
    flush_block();

    // random blocks: mostly well-formed, some cut short, some noise
    while (pending_bytes.size() < RandomBytes + 22) begin
      case ($urandom_range(99)) inside
        [0:69]:  add_block($urandom_range(6, 1), 1'b0);
        [70:84]: add_block($urandom_range(4, 1), 1'b1);
        default: add_noise();
      endcase
    end
    bytes_to_send = pending_bytes.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted != bytes_to_send) @(posedge clk_i);
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
